### src/rounded_frame_vertices_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rounded frame vertex core
// ---------------------------------------------------------------------------
`ifndef ROUNDED_FRAME_VERTICES_CORE_MACROS_SVH
`define ROUNDED_FRAME_VERTICES_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define RFV_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rounded frame vertices: check failed");

// Next-cycle implication, off while reset is asserted
`define RFV_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rounded frame vertices: check failed");

// Next-cycle implication that also holds across reset
`define RFV_ASSERT_ALW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rounded frame vertices: check failed");

`endif

### src/rfv_pkg.sv
// ---------------------------------------------------------------------------
// rfv_pkg
// Shared types, constants, cosine table and vertex list decode for the
// rounded frame vertex core.
// ---------------------------------------------------------------------------
package rfv_pkg;

    // Arc sampling and trig precision
    localparam int POINTS_PER_ARC     = 7;
    localparam int TRIG_FRACTION_BITS = 14;
    localparam int HALF_ARC           = (POINTS_PER_ARC - 1) / 2;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int XY_IN_W  = 16;
    localparam int SIZE_W   = 15;
    localparam int RADIUS_W = 14;
    localparam int COORD_W  = 18;
    localparam int IDX_W    = 5;
    localparam int COS_W    = TRIG_FRACTION_BITS + 1;
    localparam int PROD_W   = RADIUS_W + COS_W;
    localparam int JW       = $clog2(POINTS_PER_ARC);
    localparam int SEG_W    = 3;

    // Stream word widths
    localparam int S_DATA_BITS = 2 * XY_IN_W + 2 * SIZE_W + RADIUS_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = 2 * COORD_W + IDX_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    // Final vertex index of each frame kind
    localparam logic [IDX_W-1:0] LAST_IDX_FULL = IDX_W'(4 * POINTS_PER_ARC - 1);
    localparam logic [IDX_W-1:0] LAST_IDX_HALF = IDX_W'(POINTS_PER_ARC + 2 * HALF_ARC + 2);

    localparam real HALF_PI  = 1.5707963267948966;
    localparam real ARC_STEP = HALF_PI / real'(POINTS_PER_ARC - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_FULL   = 2'd0,
        CMD_TOP    = 2'd1,
        CMD_BOTTOM = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ARC_TL = 2'd0,
        ARC_TR = 2'd1,
        ARC_BR = 2'd2,
        ARC_BL = 2'd3
    } arc_t;

    typedef enum logic [1:0] {
        SEG_ARC    = 2'd0,
        SEG_DIAG_R = 2'd1,
        SEG_DIAG_L = 2'd2
    } seg_kind_t;

    // One run of the vertex list
    typedef struct packed {
        seg_kind_t       kind;
        arc_t            arc;
        logic [JW-1:0]   j_first;
        logic [JW-1:0]   j_last;
        logic            final_seg;
    } seg_t;

    // Classified rectangle, as queued between front and back
    typedef struct packed {
        cmd_t                        mode;
        logic [RADIUS_W-1:0]         radius;
        logic signed [COORD_W-1:0]   cx_l;
        logic signed [COORD_W-1:0]   cx_r;
        logic signed [COORD_W-1:0]   cy_t;
        logic signed [COORD_W-1:0]   cy_b;
        logic signed [COORD_W-1:0]   drx;
        logic signed [COORD_W-1:0]   dry;
        logic signed [COORD_W-1:0]   dlx;
        logic signed [COORD_W-1:0]   dly;
    } desc_t;

    typedef logic [POINTS_PER_ARC-1:0][COS_W-1:0] cos_tab_t;

    // First-quadrant cosines, rounded to nearest step
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t tab;
        real      ang;
        real      scaled;
        for (int j = 0; j < POINTS_PER_ARC; j++) begin
            ang    = ARC_STEP * real'(j);
            scaled = $floor($cos(ang) * (2.0 ** TRIG_FRACTION_BITS) + 0.5);
            if (scaled < 0.0) begin
                scaled = 0.0;
            end
            tab[j] = COS_W'($rtoi(scaled));
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

    function automatic seg_t mk_seg(seg_kind_t kind, arc_t arc, int jf, int jl, logic fin);
        seg_t s;
        s.kind      = kind;
        s.arc       = arc;
        s.j_first   = JW'(jf);
        s.j_last    = JW'(jl);
        s.final_seg = fin;
        return s;
    endfunction

    // Decode one run of the vertex list for a mode
    function automatic seg_t seg_info(cmd_t mode, logic [SEG_W-1:0] seg);
        seg_t s;
        s = mk_seg(SEG_DIAG_R, ARC_TL, 0, 0, 1'b1);
        unique case (mode)
            CMD_FULL: begin
                s = mk_seg(SEG_ARC, arc_t'(seg[1:0]), 0, POINTS_PER_ARC - 1,
                           seg == SEG_W'(3));
            end
            CMD_TOP: begin
                unique case (seg)
                    3'd0: s = mk_seg(SEG_ARC, ARC_TL, 0, POINTS_PER_ARC - 1, 1'b0);
                    3'd1: s = mk_seg(SEG_ARC, ARC_TR, 0, HALF_ARC, 1'b0);
                    3'd2: s = mk_seg(SEG_DIAG_R, ARC_TL, 0, 0, 1'b0);
                    3'd3: s = mk_seg(SEG_DIAG_L, ARC_TL, 0, 0, 1'b0);
                    default: s = mk_seg(SEG_ARC, ARC_BL, HALF_ARC, 2 * HALF_ARC - 1, 1'b1);
                endcase
            end
            CMD_BOTTOM: begin
                unique case (seg)
                    3'd0: s = mk_seg(SEG_ARC, ARC_TR, HALF_ARC, 2 * HALF_ARC - 1, 1'b0);
                    3'd1: s = mk_seg(SEG_ARC, ARC_BR, 0, POINTS_PER_ARC - 1, 1'b0);
                    3'd2: s = mk_seg(SEG_ARC, ARC_BL, 1, HALF_ARC + 1, 1'b0);
                    3'd3: s = mk_seg(SEG_DIAG_L, ARC_TL, 0, 0, 1'b0);
                    default: s = mk_seg(SEG_DIAG_R, ARC_TL, 0, 0, 1'b1);
                endcase
            end
            default: begin
                s = mk_seg(SEG_DIAG_R, ARC_TL, 0, 0, 1'b1);
            end
        endcase
        return s;
    endfunction

endpackage

### src/rfv_front.sv
// ---------------------------------------------------------------------------
// rfv_front
// Accepts rectangle words, drops the unused command and precomputes the arc
// centers and diagonal points for the back end.
// ---------------------------------------------------------------------------
module rfv_front import rfv_pkg::*; (
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    input  logic [CMD_W-1:0]     s_axis_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output desc_t                q_desc
);

    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] width_e;
    logic signed [COORD_W-1:0] height_e;
    logic signed [COORD_W-1:0] radius_e;
    logic signed [COORD_W-1:0] half_min;
    logic [SIZE_W-1:0]         width_f;
    logic [SIZE_W-1:0]         height_f;
    logic [SIZE_W-1:0]         min_side;
    logic [RADIUS_W-1:0]       radius_f;
    cmd_t                      cmd;

    // Unpack the word and extend to coordinate width
    always_comb begin
        cmd      = cmd_t'(s_axis_tuser);
        width_f  = s_axis_tdata[2*XY_IN_W +: SIZE_W];
        height_f = s_axis_tdata[2*XY_IN_W+SIZE_W +: SIZE_W];
        radius_f = s_axis_tdata[2*XY_IN_W+2*SIZE_W +: RADIUS_W];
        left_x   = COORD_W'($signed(s_axis_tdata[0 +: XY_IN_W]));
        top_y    = COORD_W'($signed(s_axis_tdata[XY_IN_W +: XY_IN_W]));
        width_e  = $signed({{(COORD_W-SIZE_W){1'b0}}, width_f});
        height_e = $signed({{(COORD_W-SIZE_W){1'b0}}, height_f});
        radius_e = $signed({{(COORD_W-RADIUS_W){1'b0}}, radius_f});
        min_side = (width_f < height_f) ? width_f : height_f;
        half_min = $signed({{(COORD_W-SIZE_W+1){1'b0}}, min_side[SIZE_W-1:1]});
    end

    // Build the queued descriptor
    always_comb begin
        q_desc.mode   = cmd;
        q_desc.radius = radius_f;
        q_desc.cx_l   = left_x + radius_e;
        q_desc.cx_r   = left_x + width_e - radius_e;
        q_desc.cy_t   = top_y + radius_e;
        q_desc.cy_b   = top_y + height_e - radius_e;
        q_desc.drx    = left_x + width_e - half_min;
        q_desc.dry    = top_y + half_min;
        q_desc.dlx    = left_x + half_min;
        q_desc.dly    = top_y + height_e - half_min;
    end

    // Accept whenever the queue has room; drop the unused command
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full && (cmd != CMD_NONE);

endmodule

### src/rfv_queue.sv
// ---------------------------------------------------------------------------
// rfv_queue
// Short descriptor queue that decouples the front end from the vertex
// sequencer.
// ---------------------------------------------------------------------------
module rfv_queue import rfv_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  desc_t  push_desc,
    input  logic   pop,
    output desc_t  head_desc,
    output logic   head_valid,
    output logic   full
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign head_desc  = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

### src/rfv_back.sv
// ---------------------------------------------------------------------------
// rfv_back
// Walks the vertex list of the queued rectangle, one vertex per cycle unless
// the output stalls: sequencer, multiply stage and output register.
// ---------------------------------------------------------------------------
module rfv_back import rfv_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  desc_t                      head_desc,
    input  logic                       head_valid,
    output logic                       head_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [COORD_W-1:0]  point_x,
    output logic signed [COORD_W-1:0]  point_y,
    output logic [IDX_W-1:0]           point_index,
    output logic                       point_last
);

    // Sequencer state
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [JW-1:0]     jo_reg, jo_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    seg_t              info;
    logic [JW-1:0]     cur_j;
    logic [JW-1:0]     sin_j;
    logic              seg_end;
    logic              frame_end;
    logic              advance;
    logic              issue;

    // Multiply stage
    logic [PROD_W-1:0]          prod_c;
    logic [PROD_W-1:0]          prod_s;
    logic signed [COORD_W-1:0]  base_x;
    logic signed [COORD_W-1:0]  base_y;
    logic                       s1_valid_reg;
    logic [RADIUS_W-1:0]        s1_c_reg;
    logic [RADIUS_W-1:0]        s1_s_reg;
    logic signed [COORD_W-1:0]  s1_bx_reg;
    logic signed [COORD_W-1:0]  s1_by_reg;
    arc_t                       s1_arc_reg;
    logic                       s1_is_arc_reg;
    logic [IDX_W-1:0]           s1_idx_reg;
    logic                       s1_last_reg;

    // Output stage
    logic signed [COORD_W-1:0]  c_e;
    logic signed [COORD_W-1:0]  s_e;
    logic signed [COORD_W-1:0]  dx;
    logic signed [COORD_W-1:0]  dy;
    logic                       m_valid_reg;
    logic signed [COORD_W-1:0]  px_reg;
    logic signed [COORD_W-1:0]  py_reg;
    logic [IDX_W-1:0]           pidx_reg;
    logic                       plast_reg;

    // Whole pipe moves when the output register is free or being taken
    assign advance = !m_valid_reg || m_ready;
    assign issue   = advance && head_valid;

    // Decode the current run
    always_comb begin
        info      = seg_info(head_desc.mode, seg_reg);
        cur_j     = info.j_first + jo_reg;
        sin_j     = JW'(POINTS_PER_ARC - 1) - cur_j;
        seg_end   = (info.kind != SEG_ARC) || (cur_j == info.j_last);
        frame_end = seg_end && info.final_seg;
    end

    // Step through runs and points
    always_comb begin
        seg_next = seg_reg;
        jo_next  = jo_reg;
        idx_next = idx_reg;
        head_pop = 1'b0;
        if (issue) begin
            idx_next = idx_reg + 1'b1;
            if (frame_end) begin
                seg_next = '0;
                jo_next  = '0;
                idx_next = '0;
                head_pop = 1'b1;
            end else if (seg_end) begin
                seg_next = seg_reg + 1'b1;
                jo_next  = '0;
            end else begin
                jo_next = jo_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= '0;
            jo_reg  <= '0;
            idx_reg <= '0;
        end else begin
            seg_reg <= seg_next;
            jo_reg  <= jo_next;
            idx_reg <= idx_next;
        end
    end

    // Scale cosine and sine by the radius; pick the base point
    always_comb begin
        prod_c = PROD_W'(head_desc.radius) * PROD_W'(COS_TAB[cur_j]);
        prod_s = PROD_W'(head_desc.radius) * PROD_W'(COS_TAB[sin_j]);
        base_x = head_desc.drx;
        base_y = head_desc.dry;
        case (info.kind)
            SEG_ARC: begin
                unique case (info.arc)
                    ARC_TL: begin base_x = head_desc.cx_l; base_y = head_desc.cy_t; end
                    ARC_TR: begin base_x = head_desc.cx_r; base_y = head_desc.cy_t; end
                    ARC_BR: begin base_x = head_desc.cx_r; base_y = head_desc.cy_b; end
                    default: begin base_x = head_desc.cx_l; base_y = head_desc.cy_b; end
                endcase
            end
            SEG_DIAG_L: begin
                base_x = head_desc.dlx;
                base_y = head_desc.dly;
            end
            default: begin
                base_x = head_desc.drx;
                base_y = head_desc.dry;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_c_reg      <= prod_c[TRIG_FRACTION_BITS +: RADIUS_W];
            s1_s_reg      <= prod_s[TRIG_FRACTION_BITS +: RADIUS_W];
            s1_bx_reg     <= base_x;
            s1_by_reg     <= base_y;
            s1_arc_reg    <= info.arc;
            s1_is_arc_reg <= (info.kind == SEG_ARC);
            s1_idx_reg    <= idx_reg;
            s1_last_reg   <= frame_end;
        end
    end

    // Orient the offset by quadrant
    always_comb begin
        c_e = $signed({{(COORD_W-RADIUS_W){1'b0}}, s1_c_reg});
        s_e = $signed({{(COORD_W-RADIUS_W){1'b0}}, s1_s_reg});
        dx  = '0;
        dy  = '0;
        if (s1_is_arc_reg) begin
            unique case (s1_arc_reg)
                ARC_TL: begin dx = -c_e; dy = -s_e; end
                ARC_TR: begin dx =  s_e; dy = -c_e; end
                ARC_BR: begin dx =  c_e; dy =  s_e; end
                default: begin dx = -s_e; dy = c_e; end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            px_reg    <= s1_bx_reg + dx;
            py_reg    <= s1_by_reg + dy;
            pidx_reg  <= s1_idx_reg;
            plast_reg <= s1_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_index = pidx_reg;
    assign point_last  = plast_reg;

endmodule

### src/rounded_frame_vertices_core.sv
// ---------------------------------------------------------------------------
// rounded_frame_vertices_core
// Turns a rectangle, corner radius and mode into the vertex list of a
// rounded-frame polygon.
// ---------------------------------------------------------------------------
//  channel  | direction | word
//  s_axis   | in        | one rectangle: tuser = mode, tdata = geometry
//  m_axis   | out       | one vertex: tdata = x, y, index; tlast = final vertex
//
//  A full frame has 28 vertices and a half frame 16, one vertex per cycle
//  unless the output stalls, set by the back-end sequencer and registered in
//  the multiply stage and output register. A two-entry descriptor queue holds
//  the emitted frame plus one more rectangle; mode 3 is accepted and dropped.
//  Reset is synchronous; output stalls freeze the whole back-end pipe.
// ---------------------------------------------------------------------------
module rounded_frame_vertices_core import rfv_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] left_x, [31:16] top_y, [46:32] width, [61:47] height,
    // [75:62] radius, [79:76] zero
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [17:0] point_x, [35:18] point_y, [40:36] point_index, [47:41] zero
    output logic [M_DATA_W-1:0]  m_axis_tdata,
    output logic                 m_axis_tlast
);

    desc_t                      push_desc;
    desc_t                      head_desc;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       head_valid;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [IDX_W-1:0]           point_index;

    rfv_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_desc        (push_desc)
    );

    rfv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (push_desc),
        .pop        (q_pop),
        .head_desc  (head_desc),
        .head_valid (head_valid),
        .full       (q_full)
    );

    rfv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_desc   (head_desc),
        .head_valid  (head_valid),
        .head_pop    (q_pop),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index),
        .point_last  (m_axis_tlast)
    );

    // Pack the vertex word
    assign m_axis_tdata = {{(M_DATA_W-M_DATA_BITS){1'b0}}, point_index, point_y, point_x};

endmodule

### src/rfv_checker.sv
// ---------------------------------------------------------------------------
// rfv_checker
// Port-level checks on the vertex stream of the rounded frame vertex core.
// ---------------------------------------------------------------------------
`include "rounded_frame_vertices_core_macros.svh"

module rfv_checker import rfv_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_DATA_W-1:0]  m_axis_tdata,
    input logic                 m_axis_tlast
);

    // Hold a stalled vertex word
    `RFV_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Close a frame only at the final index of a full or half frame
    `RFV_ASSERT_IMP(a_last_index, aclk, aresetn, m_axis_tvalid && m_axis_tlast, (m_axis_tdata[2*COORD_W +: IDX_W] == LAST_IDX_FULL) || (m_axis_tdata[2*COORD_W +: IDX_W] == LAST_IDX_HALF))

    // Keep the pad bits of the vertex word at zero
    `RFV_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_axis_tvalid, m_axis_tdata[M_DATA_W-1:M_DATA_BITS] == '0)

    // Drop the output after reset
    `RFV_ASSERT_ALW(a_reset_clear, aclk, !aresetn, !m_axis_tvalid)

endmodule

bind rounded_frame_vertices_core rfv_checker u_rfv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for rounded_frame_vertices_core. Rectangles go in on
// the slave stream. A scoreboard predicts the vertex list of each accepted
// rectangle and checks every vertex word on the master stream in order.
// Idle and stall profiles on both sides change between phases.
// ---------------------------------------------------------------------------
module testbench;
    import rfv_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 9;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_RECTS = 135;

    // Expected vertex, as it should appear on the master stream
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_W-1:0]          idx;
        logic                      last;
    } vertex_t;

    // -----------------------------------------------------------------------
    // Vertex list predictor and checker
    // -----------------------------------------------------------------------
    class vertex_scoreboard;
        vertex_t expected_vertices[$];
        longint  cos_q[POINTS_PER_ARC];
        longint  ctr_x[4];
        longint  ctr_y[4];
        longint  rad;
        int      vert_count;
        int      errors;
        int      rects_seen;
        int      rects_dropped;
        int      vertices_checked;

        function new();
            real step;
            real val;
            step = 3.14159265358979 / 2.0 / real'(POINTS_PER_ARC - 1);
            // cosine of each sample angle, rounded to the nearest fraction step
            for (int j = 0; j < POINTS_PER_ARC; j++) begin
                val = $floor($cos(step * real'(j)) * real'(1 << TRIG_FRACTION_BITS) + 0.5);
                if (val < 0.0) begin
                    val = 0.0;
                end
                cos_q[j] = longint'(val);
            end
            errors           = 0;
            rects_seen       = 0;
            rects_dropped    = 0;
            vertices_checked = 0;
        endfunction

        function void push_vertex(longint px, longint py);
            vertex_t v;
            v.x   = COORD_W'(px);
            v.y   = COORD_W'(py);
            v.idx = IDX_W'(vert_count);
            v.last = 1'b0;
            expected_vertices.push_back(v);
            vert_count++;
        endfunction

        // Sample points jf..jl of one corner arc
        function void push_arc(arc_t a, int jf, int jl);
            longint c;
            longint s;
            longint dx;
            longint dy;
            for (int j = jf; j <= jl; j++) begin
                c = (rad * cos_q[j]) >>> TRIG_FRACTION_BITS;
                s = (rad * cos_q[POINTS_PER_ARC - 1 - j]) >>> TRIG_FRACTION_BITS;
                case (a)
                    ARC_TL: begin
                        dx = -c; dy = -s;
                    end
                    ARC_TR: begin
                        dx = s;  dy = -c;
                    end
                    ARC_BR: begin
                        dx = c;  dy = s;
                    end
                    default: begin
                        dx = -s; dy = c;
                    end
                endcase
                push_vertex(ctr_x[int'(a)] + dx, ctr_y[int'(a)] + dy);
            end
        endfunction

        // Predict the vertex list of one accepted rectangle
        function void note_rect(cmd_t cmd, logic [S_DATA_W-1:0] d);
            longint lx;
            longint ty;
            longint w;
            longint h;
            longint half_min;
            int     hh;
            lx  = longint'($signed(d[15:0]));
            ty  = longint'($signed(d[31:16]));
            w   = longint'(d[46:32]);
            h   = longint'(d[61:47]);
            rad = longint'(d[75:62]);
            hh  = HALF_ARC;
            rects_seen++;
            if (cmd == CMD_NONE) begin
                rects_dropped++;
                return;
            end
            ctr_x[int'(ARC_TL)] = lx + rad;
            ctr_x[int'(ARC_TR)] = lx + w - rad;
            ctr_x[int'(ARC_BR)] = lx + w - rad;
            ctr_x[int'(ARC_BL)] = lx + rad;
            ctr_y[int'(ARC_TL)] = ty + rad;
            ctr_y[int'(ARC_TR)] = ty + rad;
            ctr_y[int'(ARC_BR)] = ty + h - rad;
            ctr_y[int'(ARC_BL)] = ty + h - rad;
            half_min   = ((w < h) ? w : h) >>> 1;
            vert_count = 0;
            case (cmd)
                CMD_FULL: begin
                    push_arc(ARC_TL, 0, POINTS_PER_ARC - 1);
                    push_arc(ARC_TR, 0, POINTS_PER_ARC - 1);
                    push_arc(ARC_BR, 0, POINTS_PER_ARC - 1);
                    push_arc(ARC_BL, 0, POINTS_PER_ARC - 1);
                end
                CMD_TOP: begin
                    push_arc(ARC_TL, 0, POINTS_PER_ARC - 1);
                    push_arc(ARC_TR, 0, hh);
                    push_vertex(lx + w - half_min, ty + half_min);
                    push_vertex(lx + half_min, ty + h - half_min);
                    push_arc(ARC_BL, hh, 2 * hh - 1);
                end
                default: begin
                    push_arc(ARC_TR, hh, 2 * hh - 1);
                    push_arc(ARC_BR, 0, POINTS_PER_ARC - 1);
                    push_arc(ARC_BL, 1, hh + 1);
                    push_vertex(lx + half_min, ty + h - half_min);
                    push_vertex(lx + w - half_min, ty + half_min);
                end
            endcase
            // flag the closing vertex of this polygon
            expected_vertices[expected_vertices.size() - 1].last = 1'b1;
        endfunction

        // Compare one vertex word with the oldest expectation
        function void check_vertex(logic [M_DATA_W-1:0] d, logic tl);
            vertex_t e;
            logic signed [COORD_W-1:0] ax;
            logic signed [COORD_W-1:0] ay;
            logic [IDX_W-1:0]          ai;
            ax = d[17:0];
            ay = d[35:18];
            ai = d[40:36];
            if (expected_vertices.size() == 0) begin
                $error("unexpected vertex word: x %0d y %0d index %0d", ax, ay, ai);
                errors++;
                return;
            end
            e = expected_vertices.pop_front();
            vertices_checked++;
            if (ax !== e.x) begin
                $error("point_x: expected %0d, actual %0d", e.x, ax);
                errors++;
            end
            if (ay !== e.y) begin
                $error("point_y: expected %0d, actual %0d", e.y, ay);
                errors++;
            end
            if (ai !== e.idx) begin
                $error("point_index: expected %0d, actual %0d", e.idx, ai);
                errors++;
            end
            if (tl !== e.last) begin
                $error("last: expected %0b, actual %0b", e.last, tl);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [15:0] left_x, [31:16] top_y, [46:32] width, [61:47] height,
    // [75:62] radius, [79:76] zero
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    // [1:0] command
    logic [CMD_W-1:0]    s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [17:0] point_x, [35:18] point_y, [40:36] point_index, [47:41] zero
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    int tx_idle_pct = 38;
    int rx_idle_pct = 86;
    int cycle_count = 0;

    vertex_scoreboard sb = new();

    rounded_frame_vertices_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Stall the master side at random
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watch both streams and hand accepted words to the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_rect(cmd_t'(s_axis_tuser), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_vertex(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL rounded_frame_vertices_core");
            $finish;
        end
    end

    // Offer one rectangle word and hold it until accepted
    task automatic send_rect(input cmd_t cmd, input int lx, input int ty,
                             input int w, input int h, input int r);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, RADIUS_W'(r), SIZE_W'(h), SIZE_W'(w),
                          XY_IN_W'(ty), XY_IN_W'(lx)};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Random rectangle; returns 1 when it carries a real mode
    task automatic send_random_rect(output bit counted);
        cmd_t cmd;
        int   w;
        int   h;
        int   r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            cmd = CMD_NONE;
        end else if (pick < 40) begin
            cmd = CMD_FULL;
        end else if (pick < 70) begin
            cmd = CMD_TOP;
        end else begin
            cmd = CMD_BOTTOM;
        end
        w = ($urandom_range(1) != 0) ? $urandom_range(32767) : $urandom_range(400);
        h = ($urandom_range(1) != 0) ? $urandom_range(32767) : $urandom_range(400);
        // mostly radii that fit the rectangle, some that overrun it
        if ($urandom_range(9) < 6) begin
            r = $urandom_range(((w < h) ? w : h) / 2);
        end else begin
            r = $urandom_range(16383);
        end
        send_rect(cmd, $urandom_range(65535), $urandom_range(65535), w, h, r);
        counted = (cmd != CMD_NONE);
    endtask

    // Hold the sender until every predicted vertex has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        // let the monitor log the word accepted at the last edge
        @(posedge aclk);
        while (sb.expected_vertices.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_random_phase(input int n);
        int sent;
        bit counted;
        sent = 0;
        while (sent < n) begin
            send_random_rect(counted);
            if (counted) begin
                sent++;
            end
        end
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every mode, field extremes, dropped mode, oversized radius
        send_rect(CMD_FULL,   100,    50,     200,   120,   20);
        send_rect(CMD_TOP,    100,    50,     200,   120,   20);
        send_rect(CMD_BOTTOM, 100,    50,     200,   120,   20);
        send_rect(CMD_NONE,   100,    50,     200,   120,   20);
        send_rect(CMD_FULL,   -32768, -32768, 32767, 32767, 16383);
        send_rect(CMD_TOP,    32767,  32767,  32767, 32767, 16383);
        send_rect(CMD_BOTTOM, -32768, 32767,  0,     0,     0);
        send_rect(CMD_FULL,   32767,  -32768, 0,     32767, 16383);
        send_rect(CMD_TOP,    0,      0,      10,    300,   200);
        send_rect(CMD_BOTTOM, 0,      0,      300,   11,    0);
        send_rect(CMD_FULL,   0,      0,      0,     0,     0);
        send_rect(CMD_NONE,   -1,     -1,     32767, 32767, 16383);
        send_rect(CMD_TOP,    -1,     -1,     32767, 1,     1);
        send_rect(CMD_BOTTOM, 12345,  -12345, 1,     32767, 16383);
        send_rect(CMD_FULL,   -5,     7,      31,    17,    8);
        send_rect(CMD_TOP,    32767,  -32768, 32767, 0,     16383);
        send_rect(CMD_BOTTOM, -32768, -32768, 32767, 32767, 16383);
        wait_drained();

        // Random: slow receiver, then slow sender, then full rate
        run_random_phase(PHASE_RECTS);
        wait_drained();
        tx_idle_pct = 86;
        rx_idle_pct = 38;
        run_random_phase(PHASE_RECTS);
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(PHASE_RECTS);

        // Drain and watch for stray words
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d vertices from %0d rectangles (%0d with the unused mode),",
                 sb.vertices_checked, sb.rects_seen, sb.rects_dropped);
        $display("under slow-receiver, slow-sender and full-rate handshakes.");
        if (sb.errors == 0) begin
            $display("PASS rounded_frame_vertices_core");
        end else begin
            $display("FAIL rounded_frame_vertices_core");
        end
        $finish;
    end

endmodule
